// ===== rtl/u8d_pkg.sv =====
// Shared types, constants and helper functions of the UTF-8 byte stream decoder.
// Depends on nothing; used by u8d_decode and utf8_byte_stream_decoder.

package u8d_pkg;

	localparam int ByteW  = 8;
	localparam int CpW    = 21;
	localparam int MaxRes = 3;
	localparam int HeldN  = 3;
	localparam int TailN  = 8;

	typedef logic [ByteW-1:0]               byte_t;
	typedef logic [CpW-1:0]                 cp_t;
	typedef logic [1:0]                     cnt_t;
	typedef logic [HeldN-1:0][ByteW-1:0]    held_t;
	typedef logic [MaxRes-1:0][CpW-1:0]     cp_list_t;

	// Lead byte classes
	localparam byte_t AsciiMax  = 8'h7F;
	localparam byte_t Lead2Mask = 8'hE0;
	localparam byte_t Lead2Code = 8'hC0;
	localparam byte_t Lead3Mask = 8'hF0;
	localparam byte_t Lead3Code = 8'hE0;
	localparam byte_t Lead4Mask = 8'hF8;
	localparam byte_t Lead4Code = 8'hF0;

	// Decoder state: gathered bytes, count held (lead included), bytes the lead needs
	typedef struct packed {
		held_t held;
		cnt_t  hc;
		cnt_t  need;
	} u8d_state_t;

	// Results caused by one word
	typedef struct packed {
		cnt_t     count;
		cp_list_t cp;
	} u8d_res_t;

	// Number of following bytes a lead calls for; zero for anything else
	function automatic cnt_t follow_of(byte_t c);
		cnt_t f;
		f = 2'd0;
		if ((c & Lead2Mask) == Lead2Code) f = 2'd1;
		else if ((c & Lead3Mask) == Lead3Code) f = 2'd2;
		else if ((c & Lead4Mask) == Lead4Code) f = 2'd3;
		return f;
	endfunction

	// Build a code point from a lead and its following bytes
	function automatic cp_t assemble(byte_t b0, byte_t b1, byte_t b2, byte_t b3, cnt_t follow);
		cp_t cp;
		case (follow)
			2'd1: cp = {10'd0, b0[4:0], b1[5:0]};
			2'd2: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
		endcase
		return cp;
	endfunction

endpackage

// ===== rtl/utf8_byte_stream_decoder.sv =====
// A code point shows on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle while each byte gives at most one code point and the
// master side is ready; a final byte that gives n code points (at most 2) holds the slave
// side until the last is taken, as the single result register sends one per ready cycle.
// Reset: arst_n clears the sequence state and empties the result register at once.
// Top level of the UTF-8 byte stream decoder; depends on u8d_pkg and u8d_decode.

module utf8_byte_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // final_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [20:0] code_point, [23:21] zero
	output logic        m_axis_tlast   // run_end
);
	import u8d_pkg::*;

	held_t      held_q;
	cnt_t       hc_q;
	cnt_t       need_q;
	u8d_state_t cur;
	u8d_state_t nxt;
	u8d_res_t   res;
	cp_list_t   cp_q;
	cnt_t       total_q;
	cnt_t       rem_q;
	cnt_t       out_idx;
	logic       in_acc;
	logic       out_acc;

	assign cur = '{held: held_q, hc: hc_q, need: need_q};

	u8d_decode u_decode (
		.cur        (cur),
		.data_byte  (s_axis_tdata),
		.final_byte (s_axis_tlast),
		.nxt        (nxt),
		.res        (res)
	);

	// Take a new word when the result register is empty or empties this cycle
	assign out_acc       = m_axis_tvalid & m_axis_tready;
	assign s_axis_tready = (rem_q == 2'd0) || (rem_q == 2'd1 && m_axis_tready);
	assign in_acc        = s_axis_tvalid & s_axis_tready;

	// Sequence control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q   <= '0;
			need_q <= '0;
		end else if (in_acc) begin
			hc_q   <= nxt.hc;
			need_q <= nxt.need;
		end
	end

	// Held bytes: payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			held_q <= nxt.held;
		end
	end

	// Result register: load a new batch or advance by one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rem_q   <= '0;
		end else if (in_acc) begin
			total_q <= res.count;
			rem_q   <= res.count;
		end else if (out_acc) begin
			rem_q   <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cp_q <= res.cp;
		end
	end

	// Drive the master side from the oldest pending code point
	assign out_idx       = total_q - rem_q;
	assign m_axis_tvalid = (rem_q != 2'd0);
	assign m_axis_tdata  = {3'd0, cp_q[out_idx]};
	assign m_axis_tlast  = (rem_q == 2'd1);

endmodule

// ===== rtl/u8d_decode.sv =====
// Combinational decode of one byte against the held sequence state.
// Depends on u8d_pkg; instantiated by utf8_byte_stream_decoder.

module u8d_decode (
	input  u8d_pkg::u8d_state_t cur,
	input  u8d_pkg::byte_t      data_byte,
	input  logic                final_byte,
	output u8d_pkg::u8d_state_t nxt,
	output u8d_pkg::u8d_res_t   res
);
	import u8d_pkg::*;

	byte_t      tail [TailN];
	logic [2:0] tail_len;
	logic [2:0] pos;
	byte_t      tc;
	cnt_t       tf;
	cnt_t       k;
	cnt_t       lead_f;

	assign lead_f = follow_of(data_byte);

	always_comb begin
		// Lay out the string tail: held bytes, then the final byte
		for (int j = 0; j < TailN; j++) begin
			tail[j] = '0;
		end
		for (int j = 0; j < HeldN; j++) begin
			tail[j] = cur.held[j];
		end
		tail[{1'b0, cur.hc}] = data_byte;
		tail_len = {1'b0, cur.hc} + 3'd1;

		nxt = cur;
		res = '0;
		pos = '0;
		k   = '0;
		tc  = '0;
		tf  = '0;

		if (final_byte) begin
			// Walk the tail once, position by position
			for (int p = 0; p < 4; p++) begin
				if (3'(p) < tail_len && 3'(p) == pos) begin
					tc = tail[p];
					tf = follow_of(tc);
					if (tc <= AsciiMax) begin
						if (k < 2'd3) res.cp[k] = {13'd0, tc};
						k = k + 2'd1;
						pos = pos + 3'd1;
					end else if (tf != 2'd0 && (3'(p) + {1'b0, tf}) < tail_len) begin
						if (k < 2'd3) begin
							res.cp[k] = assemble(tail[p], tail[p+1], tail[p+2], tail[p+3], tf);
						end
						k = k + 2'd1;
						pos = 3'(p) + {1'b0, tf} + 3'd1;
					end else begin
						pos = pos + 3'd1;
					end
				end
			end
			res.count = k;
			nxt.hc    = '0;
			nxt.need  = '0;
		end else if (cur.hc != 2'd0) begin
			if (cur.hc >= cur.need) begin
				// Sequence complete with this byte
				case (cur.need)
					2'd1: res.cp[0] = assemble(cur.held[0], data_byte, 8'd0, 8'd0, cur.need);
					2'd2: res.cp[0] = assemble(cur.held[0], cur.held[1], data_byte, 8'd0,
						cur.need);
					default: res.cp[0] = assemble(cur.held[0], cur.held[1], cur.held[2],
						data_byte, cur.need);
				endcase
				res.count = 2'd1;
				nxt.hc    = '0;
				nxt.need  = '0;
			end else begin
				// Gather one more following byte
				nxt.held[cur.hc] = data_byte;
				nxt.hc = cur.hc + 2'd1;
			end
		end else begin
			if (data_byte <= AsciiMax) begin
				res.cp[0] = {13'd0, data_byte};
				res.count = 2'd1;
			end else if (lead_f != 2'd0) begin
				nxt.held[0] = data_byte;
				nxt.hc      = 2'd1;
				nxt.need    = lead_f;
			end
		end
	end

endmodule

// ===== rtl/u8d_checker.sv =====
// Port-level checks of the UTF-8 byte stream decoder, bound to its top level.
// Depends on utf8_byte_stream_decoder's ports only.

module u8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// Stall the slave side only while results wait
	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("slave side stalled with no result pending");

	// A word that is not the last of its batch is followed by another
	a_batch_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("batch of code points cut short");

	// Code points stay within 21 bits
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:21] == 3'd0))
		else $error("code point padding not zero");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("stalled result changed");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
